[hw/rtl/mlc_pkg.sv]
// ----------------------------------------------------------------------------
// mlc_pkg
// Shared widths, register indexes, sideband type and log2 table builder.
// ----------------------------------------------------------------------------
package mlc_pkg;

  localparam int FS_W       = 15;
  localparam int MU_W       = 10;
  localparam int V_W        = 25;
  localparam int E_W        = 5;
  localparam int TBL_BITS   = 6;
  localparam int TBL_SIZE   = 64;
  localparam int REM_W      = V_W - TBL_BITS - 1;
  localparam int QUO_W      = 15;
  localparam int CFG_ADDR_W = 2;
  localparam int CFG_DATA_W = 16;

  localparam int SAMPLE_BITS_DEF   = 16;
  localparam int LOG_FRAC_BITS_DEF = 16;

  localparam logic [CFG_ADDR_W-1:0] CFG_FULL_SCALE = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] CFG_COMP_RATIO = 2'd1;

  localparam logic [FS_W-1:0] FS_RESET = 15'd32767;
  localparam logic [MU_W-1:0] MU_RESET = 10'd255;

  typedef struct packed {
    logic            neg;
    logic            clip;
    logic            mu_zero;
    logic [FS_W-1:0] a;
    logic [FS_W-1:0] fs;
  } mlc_side_t;

  // log2(1 + k/64) by repeated squaring, rounded to f fraction bits
  function automatic logic [24:0] log_tbl_entry(input int k, input int f);
    logic [63:0] m;
    logic [63:0] r;
    m = 64'(TBL_SIZE + k) << (30 - TBL_BITS);
    r = '0;
    for (int i = 0; i < 24; i++) begin
      m = (m * m) >> 30;
      r = r << 1;
      if (m >= (64'd1 << 31)) begin
        r = r | 64'd1;
        m = m >> 1;
      end
    end
    if (f < 24) r = (r + (64'd1 << (23 - f))) >> (24 - f);
    if (k == TBL_SIZE) r = 64'd1 << f;
    return r[24:0];
  endfunction

endpackage

[hw/rtl/mlc_log2.sv]
// ----------------------------------------------------------------------------
// mlc_log2
// Two-stage fixed-point log2: leading one and table read, then interpolation.
// ----------------------------------------------------------------------------
module mlc_log2 #(
  parameter int LOG_FRAC_BITS = mlc_pkg::LOG_FRAC_BITS_DEF
) (
  input  logic                                     clk_i,
  input  logic                                     en_i,
  input  logic [mlc_pkg::V_W-1:0]                  v_i,
  output logic [LOG_FRAC_BITS+mlc_pkg::E_W-1:0]    l_o
);
  import mlc_pkg::*;

  localparam int F   = LOG_FRAC_BITS;
  localparam int L_W = F + E_W;
  localparam int P_W = F + 1 + REM_W;

  logic [F:0] tbl [TBL_SIZE+1];

  for (genvar k = 0; k <= TBL_SIZE; k++) begin : g_tbl
    localparam logic [24:0] ENT = log_tbl_entry(k, F);
    assign tbl[k] = ENT[F:0];
  end

  logic [V_W-1:0]      vn;
  logic [E_W-1:0]      e;
  logic [TBL_BITS-1:0] idx;
  logic [REM_W-1:0]    rem_d;
  logic [E_W-1:0]      sh_d;
  logic [F:0]          lo_d, diff_d;
  logic [V_W-1:0]      shv;

  always_comb begin
    vn = (v_i == '0) ? V_W'(1) : v_i;
    e  = '0;
    for (int i = 0; i < V_W; i++) begin
      if (vn[i]) e = E_W'(i);
    end
    if (e >= E_W'(TBL_BITS)) begin
      shv = vn >> (e - E_W'(TBL_BITS));
    end else begin
      shv = vn << (E_W'(TBL_BITS) - e);
    end
    idx = shv[TBL_BITS-1:0];
    if (e > E_W'(TBL_BITS)) begin
      sh_d  = e - E_W'(TBL_BITS);
      rem_d = REM_W'(vn & ((V_W'(1) << sh_d) - V_W'(1)));
    end else begin
      sh_d  = '0;
      rem_d = '0;
    end
    lo_d   = tbl[{1'b0, idx}];
    diff_d = tbl[{1'b0, idx} + 7'd1] - lo_d;
  end

  logic [E_W-1:0]   e_q, sh_q;
  logic [REM_W-1:0] rem_q;
  logic [F:0]       lo_q, diff_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      e_q    <= e;
      sh_q   <= sh_d;
      rem_q  <= rem_d;
      lo_q   <= lo_d;
      diff_q <= diff_d;
    end
  end

  logic [P_W-1:0] prod, rnd, term;
  logic [L_W-1:0] l_d, l_q;

  always_comb begin
    prod = P_W'(diff_q) * P_W'(rem_q);
    rnd  = (sh_q != '0) ? (P_W'(1) << (sh_q - E_W'(1))) : '0;
    term = (prod + rnd) >> sh_q;
    l_d  = (L_W'(e_q) << F) + L_W'(lo_q) + L_W'(term);
  end

  always_ff @(posedge clk_i) begin
    if (en_i) l_q <= l_d;
  end

  assign l_o = l_q;

endmodule

[hw/rtl/mlc_div.sv]
// ----------------------------------------------------------------------------
// mlc_div
// Pipelined restoring divider, one quotient bit per stage, with overflow flag.
// ----------------------------------------------------------------------------
module mlc_div #(
  parameter int LOG_FRAC_BITS = mlc_pkg::LOG_FRAC_BITS_DEF
) (
  input  logic                                        clk_i,
  input  logic                                        rst_ni,
  input  logic                                        en_i,
  input  logic                                        valid_i,
  input  logic [LOG_FRAC_BITS+mlc_pkg::E_W+16:0]      num_i,
  input  logic [LOG_FRAC_BITS+mlc_pkg::E_W:0]         den_i,
  input  mlc_pkg::mlc_side_t                          side_i,
  output logic                                        valid_o,
  output logic [mlc_pkg::QUO_W-1:0]                   quo_o,
  output logic                                        sat_o,
  output mlc_pkg::mlc_side_t                          side_o
);
  import mlc_pkg::*;

  localparam int L_W = LOG_FRAC_BITS + E_W;
  localparam int N_W = L_W + 17;
  localparam int D_W = L_W + 1;

  logic             vld_q  [QUO_W];
  logic [N_W-1:0]   rem_q  [QUO_W];
  logic [D_W-1:0]   den_q  [QUO_W];
  logic [QUO_W-1:0] quo_q  [QUO_W];
  logic             sat_q  [QUO_W];
  mlc_side_t        side_q [QUO_W];

  for (genvar j = 0; j < QUO_W; j++) begin : g_stage
    localparam int B = QUO_W - 1 - j;
    logic             vld_in;
    logic [N_W-1:0]   rem_in, rem_d, dsh;
    logic [D_W-1:0]   den_in;
    logic [QUO_W-1:0] quo_in, quo_d;
    logic             sat_in;
    mlc_side_t        side_in;

    if (j == 0) begin : g_first
      assign vld_in  = valid_i;
      assign rem_in  = num_i;
      assign den_in  = den_i;
      assign quo_in  = '0;
      assign sat_in  = (num_i >> QUO_W) >= N_W'(den_i);
      assign side_in = side_i;
    end else begin : g_next
      assign vld_in  = vld_q[j-1];
      assign rem_in  = rem_q[j-1];
      assign den_in  = den_q[j-1];
      assign quo_in  = quo_q[j-1];
      assign sat_in  = sat_q[j-1];
      assign side_in = side_q[j-1];
    end

    always_comb begin
      dsh   = N_W'(den_in) << B;
      rem_d = rem_in;
      quo_d = quo_in;
      if (rem_in >= dsh) begin
        rem_d    = rem_in - dsh;
        quo_d[B] = 1'b1;
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[j] <= 1'b0;
      end else if (en_i) begin
        vld_q[j] <= vld_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[j]  <= rem_d;
        den_q[j]  <= den_in;
        quo_q[j]  <= quo_d;
        sat_q[j]  <= sat_in;
        side_q[j] <= side_in;
      end
    end
  end

  assign valid_o = vld_q[QUO_W-1];
  assign quo_o   = quo_q[QUO_W-1];
  assign sat_o   = sat_q[QUO_W-1];
  assign side_o  = side_q[QUO_W-1];

endmodule

[hw/rtl/mu_law_compressor_core.sv]
// ----------------------------------------------------------------------------
// mu_law_compressor_core
// Continuous mu-law compressor: y = sign(x)*M*log2(1+mu*|x|/M)/log2(1+mu).
// ----------------------------------------------------------------------------
// One sample is taken per clock while the output is not stalled, and each gives
// one result after the input register, multiply, two log2 stages, scale, 15
// divider stages and the output register.
// A stall on the output side holds the whole pipeline; nothing is dropped.
// Configuration (index 0 full_scale, index 1 compression_ratio) is always
// ready and should be written only while no beat is in flight.
module mu_law_compressor_core #(
  parameter int SAMPLE_BITS   = mlc_pkg::SAMPLE_BITS_DEF,
  parameter int LOG_FRAC_BITS = mlc_pkg::LOG_FRAC_BITS_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [mlc_pkg::CFG_ADDR_W-1:0]      cfg_addr_i,
  input  logic [mlc_pkg::CFG_DATA_W-1:0]      cfg_data_i,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  input  logic [((SAMPLE_BITS+7)/8)*8-1:0]    s_axis_tdata,   // sample_in
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  output logic [((SAMPLE_BITS+7)/8)*8-1:0]    m_axis_tdata,   // sample_out
  output logic                                m_axis_tuser    // clipped
);
  import mlc_pkg::*;

  localparam int TD_W  = ((SAMPLE_BITS + 7) / 8) * 8;
  localparam int L_W   = LOG_FRAC_BITS + E_W;
  localparam int N_W   = L_W + 17;
  localparam int D_W   = L_W + 1;
  localparam int CMP_W = (SAMPLE_BITS > FS_W) ? SAMPLE_BITS : FS_W;

  logic [FS_W-1:0] fs_q;
  logic [MU_W-1:0] mu_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fs_q <= FS_RESET;
      mu_q <= MU_RESET;
    end else if (cfg_valid_i) begin
      case (cfg_addr_i)
        CFG_FULL_SCALE: fs_q <= cfg_data_i[FS_W-1:0];
        CFG_COMP_RATIO: mu_q <= cfg_data_i[MU_W-1:0];
        default: ;
      endcase
    end
  end

  logic out_vld_q;
  logic en;

  assign en            = !out_vld_q || m_axis_tready;
  assign s_axis_tready = en;

  // stage 1: magnitude and saturation
  logic [SAMPLE_BITS-1:0] raw, mag;
  logic [CMP_W-1:0]       mag_x, fs_x;
  logic [FS_W-1:0]        fs_eff;
  mlc_side_t              side1_d, side1_q;
  logic                   v1_q;
  logic [MU_W-1:0]        mu1_q;

  always_comb begin
    raw             = s_axis_tdata[SAMPLE_BITS-1:0];
    side1_d.neg     = raw[SAMPLE_BITS-1];
    mag             = side1_d.neg ? (~raw + SAMPLE_BITS'(1)) : raw;
    fs_eff          = (fs_q == '0) ? FS_W'(1) : fs_q;
    mag_x           = CMP_W'(mag);
    fs_x            = CMP_W'(fs_eff);
    side1_d.clip    = mag_x > fs_x;
    side1_d.a       = side1_d.clip ? fs_eff : mag_x[FS_W-1:0];
    side1_d.fs      = fs_eff;
    side1_d.mu_zero = (mu_q == '0);
  end

  // stage 2: log arguments
  logic [V_W-1:0] vn_d, vn_q, vd_q, vc_q;
  mlc_side_t      side2_q, side3_q, side4_q, side5_q;
  logic           v2_q, v3_q, v4_q, v5_q;

  assign vn_d = V_W'(side1_q.fs) + V_W'(mu1_q) * V_W'(side1_q.a);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      v5_q <= 1'b0;
    end else if (en) begin
      v1_q <= s_axis_tvalid;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
      v5_q <= v4_q;
    end
  end

  logic [L_W-1:0] ln, ld, lc;
  logic [L_W-1:0] dd;
  logic [N_W-1:0] num_d, num_q;
  logic [D_W-1:0] den_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      side1_q <= side1_d;
      mu1_q   <= mu_q;
      vn_q    <= vn_d;
      vd_q    <= V_W'(side1_q.fs);
      vc_q    <= V_W'(mu1_q) + V_W'(1);
      side2_q <= side1_q;
      side3_q <= side2_q;
      side4_q <= side3_q;
      side5_q <= side4_q;
      num_q   <= num_d;
      den_q   <= {lc, 1'b0};
    end
  end

  // stages 3 and 4: log2 units
  mlc_log2 #(.LOG_FRAC_BITS(LOG_FRAC_BITS)) u_log_n (
    .clk_i, .en_i(en), .v_i(vn_q), .l_o(ln)
  );
  mlc_log2 #(.LOG_FRAC_BITS(LOG_FRAC_BITS)) u_log_d (
    .clk_i, .en_i(en), .v_i(vd_q), .l_o(ld)
  );
  mlc_log2 #(.LOG_FRAC_BITS(LOG_FRAC_BITS)) u_log_c (
    .clk_i, .en_i(en), .v_i(vc_q), .l_o(lc)
  );

  // stage 5: scaled numerator
  always_comb begin
    dd    = (ln > ld) ? (ln - ld) : '0;
    num_d = N_W'({side4_q.fs, 1'b0}) * N_W'(dd) + N_W'(lc);
  end

  logic             dv;
  logic [QUO_W-1:0] quo;
  logic             sat;
  mlc_side_t        dside;

  mlc_div #(.LOG_FRAC_BITS(LOG_FRAC_BITS)) u_div (
    .clk_i,
    .rst_ni,
    .en_i    (en),
    .valid_i (v5_q),
    .num_i   (num_q),
    .den_i   (den_q),
    .side_i  (side5_q),
    .valid_o (dv),
    .quo_o   (quo),
    .sat_o   (sat),
    .side_o  (dside)
  );

  // output register
  logic [FS_W-1:0]        y;
  logic [FS_W:0]          ys;
  logic [SAMPLE_BITS-1:0] out_d, out_q;
  logic                   clip_q;

  always_comb begin
    if (dside.mu_zero) begin
      y = dside.a;
    end else if (sat || (quo > dside.fs)) begin
      y = dside.fs;
    end else begin
      y = quo;
    end
    ys    = dside.neg ? (~{1'b0, y} + (FS_W+1)'(1)) : {1'b0, y};
    out_d = SAMPLE_BITS'($signed(ys));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (en) begin
      out_vld_q <= dv;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_q  <= out_d;
      clip_q <= dside.clip;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = TD_W'(out_q);
  assign m_axis_tuser  = clip_q;

endmodule
